>>> rtl/ilst_pkg.sv
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared types and constants for the idle LED and sleep timer unit.
// ----------------------------------------------------------------------------
package ilst_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned LimitW = 26;
    localparam int unsigned CmdW   = 2;
    localparam int unsigned SendW  = 2;
    localparam int unsigned IdxW   = 3;
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 8;

    // Event codes.
    localparam logic [CmdW-1:0] CMD_TICK     = 2'd0;
    localparam logic [CmdW-1:0] CMD_KEY      = 2'd1;
    localparam logic [CmdW-1:0] CMD_LINK     = 2'd2;
    localparam logic [CmdW-1:0] CMD_NEW_CONN = 2'd3;

    // Sleep command codes.
    localparam logic [SendW-1:0] SEND_NONE      = 2'd0;
    localparam logic [SendW-1:0] SEND_BROADCAST = 2'd1;
    localparam logic [SendW-1:0] SEND_WIRED     = 2'd2;

    // Register indexes.
    localparam logic [IdxW-1:0] REG_USB_IDLE    = 3'd0;
    localparam logic [IdxW-1:0] REG_RADIO_IDLE  = 3'd1;
    localparam logic [IdxW-1:0] REG_SIDES_EN    = 3'd2;
    localparam logic [IdxW-1:0] REG_SIDES_SLEEP = 3'd3;
    localparam logic [IdxW-1:0] REG_WIRED_SLEEP = 3'd4;

    localparam logic [LimitW-1:0] USB_IDLE_RST    = 26'd600000;
    localparam logic [LimitW-1:0] RADIO_IDLE_RST  = 26'd600000;
    localparam logic [LimitW-1:0] SIDES_SLEEP_RST = 26'd600000;
    localparam logic [LimitW-1:0] WIRED_SLEEP_RST = 26'd1200000;

    typedef struct packed {
        logic [LimitW-1:0] usb_idle_ms;
        logic [LimitW-1:0] radio_idle_ms;
        logic              sides_sleep_enable;
        logic [LimitW-1:0] sides_sleep_ms;
        logic [LimitW-1:0] wired_sleep_ms;
    } cfg_t;

    typedef struct packed {
        logic [CmdW-1:0]  cmd;
        logic [TimeW-1:0] now_ms;
        logic             left_wired;
        logic             right_wired;
        logic             radio_up;
    } item_t;

    typedef struct packed {
        logic [TimeW-1:0] wired_mark;
        logic [TimeW-1:0] radio_mark;
        logic [TimeW-1:0] sides_sleep_mark;
        logic [TimeW-1:0] wired_sleep_mark;
        logic             asleep;
        logic             idled;
        logic             pending_connection;
        logic             led_state;
    } state_t;

    typedef struct packed {
        logic             leds_on;
        logic [SendW-1:0] sleep_send;
        logic             idle_now;
    } result_t;

endpackage

>>> rtl/ilst_core.sv
// ----------------------------------------------------------------------------
// ilst_core
// Next-state and result logic for one event of the idle LED and sleep timer.
// ----------------------------------------------------------------------------
module ilst_core (
    input  ilst_pkg::cfg_t    cfg,
    input  ilst_pkg::item_t   item,
    input  ilst_pkg::state_t  state_cur,
    output ilst_pkg::state_t  state_nxt,
    output ilst_pkg::result_t res
);

    always_comb
    begin
        ilst_pkg::state_t                 st;
        logic [ilst_pkg::SendW-1:0]       send;
        logic [ilst_pkg::TimeW-1:0]       d_idle;
        logic [ilst_pkg::TimeW-1:0]       d_sleep;
        logic                             wired_mode;

        st         = state_cur;
        send       = ilst_pkg::SEND_NONE;
        wired_mode = item.left_wired && item.right_wired && !item.radio_up;
        d_idle     = '0;
        d_sleep    = '0;

        case (item.cmd)
            ilst_pkg::CMD_TICK:
            begin
                if (wired_mode)
                begin
                    d_idle = item.now_ms - st.wired_mark;
                    if ((cfg.usb_idle_ms != '0) && st.led_state &&
                        (d_idle > {6'd0, cfg.usb_idle_ms}))
                    begin
                        st.led_state        = 1'b0;
                        st.wired_sleep_mark = item.now_ms;
                        st.asleep           = 1'b0;
                        st.idled            = 1'b1;
                    end
                    // The sleep check measures from the mark as just updated.
                    d_sleep = item.now_ms - st.wired_sleep_mark;
                    if (!st.asleep && (d_sleep > {6'd0, cfg.wired_sleep_ms}))
                    begin
                        send                = ilst_pkg::SEND_WIRED;
                        st.asleep           = 1'b1;
                        st.wired_sleep_mark = item.now_ms;
                    end
                end
                else
                begin
                    d_idle = item.now_ms - st.radio_mark;
                    if ((cfg.radio_idle_ms != '0) && st.led_state &&
                        (d_idle > {6'd0, cfg.radio_idle_ms}))
                    begin
                        st.led_state        = 1'b0;
                        st.idled            = 1'b1;
                        st.asleep           = 1'b0;
                        st.sides_sleep_mark = item.now_ms;
                    end
                    d_sleep = item.now_ms - st.sides_sleep_mark;
                    if (cfg.sides_sleep_enable && !st.led_state && !st.asleep &&
                        (d_sleep > {6'd0, cfg.sides_sleep_ms}))
                    begin
                        send      = ilst_pkg::SEND_BROADCAST;
                        st.asleep = 1'b1;
                    end
                end
            end
            ilst_pkg::CMD_KEY:
            begin
                if (st.idled)
                begin
                    st.led_state = 1'b1;
                    st.idled     = 1'b0;
                end
                st.wired_mark       = item.now_ms;
                st.radio_mark       = item.now_ms;
                st.sides_sleep_mark = item.now_ms;
                st.wired_sleep_mark = item.now_ms;
                st.asleep           = 1'b0;
            end
            ilst_pkg::CMD_LINK:
            begin
                if (st.pending_connection)
                begin
                    st.pending_connection = 1'b0;
                    st.wired_mark         = item.now_ms;
                    st.radio_mark         = item.now_ms;
                    st.sides_sleep_mark   = item.now_ms;
                    st.wired_sleep_mark   = item.now_ms;
                    st.asleep             = 1'b0;
                end
                st.led_state = 1'b1;
            end
            default:
            begin
                st.pending_connection = 1'b1;
            end
        endcase

        state_nxt      = st;
        res.leds_on    = st.led_state;
        res.sleep_send = send;
        res.idle_now   = st.idled;
    end

endmodule

>>> rtl/idle_led_and_sleep_timer_unit.sv
// ----------------------------------------------------------------------------
// idle_led_and_sleep_timer_unit
// Idle LED shutoff and side sleep timer driven by a stream of timed events.
// ----------------------------------------------------------------------------
// Events enter on the s_ group: s_tuser carries the event code and s_tdata
// the millisecond time stamp and the link status bits. Every event yields
// exactly one result word on the m_ group: LED enable, sleep command and
// the idled flag, all as they stand after that event.
// An accepted event is held in an input register; once the result register
// is free or its word is being taken, the event logic updates the timer
// state and loads the result register. One event per cycle is sustained
// while the receiver takes every result word.
// When the receiver stalls, the result holds, the input register fills and
// s_tready drops until the result is taken; nothing is lost.
// Limits go over the always-ready cfg_ channel; the user must keep writes to
// times when no event is in flight, as the block does not enforce it. Reset
// restores the default limits, zeroes all time marks and turns the LEDs on.
// ----------------------------------------------------------------------------
module idle_led_and_sleep_timer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Bits from 0: now_ms[31:0], left_wired, right_wired, radio_up, zero fill.
    input  logic [ilst_pkg::InDataW-1:0]  s_tdata,
    // Bits from 0: cmd[1:0].
    input  logic [ilst_pkg::CmdW-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Bits from 0: leds_on, sleep_send[1:0], idle_now, zero fill.
    output logic [ilst_pkg::OutDataW-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ilst_pkg::IdxW-1:0]     cfg_index,
    input  logic [ilst_pkg::LimitW-1:0]   cfg_data
);

    logic              in_valid_reg;
    ilst_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    ilst_pkg::result_t out_res_reg;
    ilst_pkg::state_t  state_reg;
    ilst_pkg::state_t  state_next;
    ilst_pkg::cfg_t    cfg_reg;
    ilst_pkg::result_t res_next;
    logic              advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'd0, out_res_reg.idle_now, out_res_reg.sleep_send,
                        out_res_reg.leds_on};

    ilst_core u_core (
        .cfg       (cfg_reg),
        .item      (in_item_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.cmd         <= s_tuser;
            in_item_reg.now_ms      <= s_tdata[31:0];
            in_item_reg.left_wired  <= s_tdata[32];
            in_item_reg.right_wired <= s_tdata[33];
            in_item_reg.radio_up    <= s_tdata[34];
        end
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.wired_mark         <= '0;
            state_reg.radio_mark         <= '0;
            state_reg.sides_sleep_mark   <= '0;
            state_reg.wired_sleep_mark   <= '0;
            state_reg.asleep             <= 1'b0;
            state_reg.idled              <= 1'b0;
            state_reg.pending_connection <= 1'b0;
            state_reg.led_state          <= 1'b1;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.usb_idle_ms        <= ilst_pkg::USB_IDLE_RST;
            cfg_reg.radio_idle_ms      <= ilst_pkg::RADIO_IDLE_RST;
            cfg_reg.sides_sleep_enable <= 1'b0;
            cfg_reg.sides_sleep_ms     <= ilst_pkg::SIDES_SLEEP_RST;
            cfg_reg.wired_sleep_ms     <= ilst_pkg::WIRED_SLEEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ilst_pkg::REG_USB_IDLE:    cfg_reg.usb_idle_ms        <= cfg_data;
                ilst_pkg::REG_RADIO_IDLE:  cfg_reg.radio_idle_ms      <= cfg_data;
                ilst_pkg::REG_SIDES_EN:    cfg_reg.sides_sleep_enable <= cfg_data[0];
                ilst_pkg::REG_SIDES_SLEEP: cfg_reg.sides_sleep_ms     <= cfg_data;
                ilst_pkg::REG_WIRED_SLEEP: cfg_reg.wired_sleep_ms     <= cfg_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

>>> rtl/ilst_checker.sv
// ----------------------------------------------------------------------------
// ilst_checker
// Port-level assertions for the idle LED and sleep timer unit.
// ----------------------------------------------------------------------------
module ilst_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ilst_pkg::OutDataW-1:0] m_tdata
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // Input backpressure only comes from a stalled, full output.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // The sleep command code never takes the unused value.
    a_send_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:1] != 2'd3))
        else $error("invalid sleep command code");

    // A broadcast sleep is only sent with the LEDs off.
    a_broadcast_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:1] == ilst_pkg::SEND_BROADCAST)) |-> !m_tdata[0])
        else $error("broadcast sleep with LEDs on");

endmodule

bind idle_led_and_sleep_timer_unit ilst_checker u_ilst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/idle_timer_checker.sv
// ----------------------------------------------------------------------------
// idle_timer_checker
// Watches the event, result and register channels of the idle LED and sleep
// timer unit. It keeps its own copy of the limits and timer state, works out
// the status word each accepted event must produce, and compares every
// result word against the oldest outstanding status, field by field.
// ----------------------------------------------------------------------------
module idle_timer_checker
    import ilst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // Bits from 0: now_ms[31:0], left_wired, right_wired, radio_up, zero fill.
    input  logic [InDataW-1:0]  s_tdata,
    // Bits from 0: cmd[1:0].
    input  logic [CmdW-1:0]     s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // Bits from 0: leds_on, sleep_send[1:0], idle_now, zero fill.
    input  logic [OutDataW-1:0] m_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [IdxW-1:0]     cfg_index,
    input  logic [LimitW-1:0]   cfg_data,
    output int unsigned         mismatches,
    output int unsigned         in_flight
);

    timeunit 1ns;
    timeprecision 1ps;

    cfg_t    limits;
    state_t  timers;
    result_t status_due[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        // Keep the log short when something goes badly wrong.
        if (mismatches < 40)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Deadlines pass only when the wrapped elapsed time is strictly larger.
    function automatic logic expired(input logic [TimeW-1:0] now,
                                     input logic [TimeW-1:0] mark,
                                     input logic [LimitW-1:0] limit);
        logic [TimeW-1:0] span;
        span = now - mark;
        return span > TimeW'(limit);
    endfunction

    task automatic restart_marks(input logic [TimeW-1:0] now);
        timers.wired_mark       = now;
        timers.radio_mark       = now;
        timers.sides_sleep_mark = now;
        timers.wired_sleep_mark = now;
        timers.asleep           = 1'b0;
    endtask

    task automatic step_idle_timers(input item_t ev, output result_t status);
        logic wired_mode;
        status.sleep_send = SEND_NONE;
        wired_mode = ev.left_wired && ev.right_wired && !ev.radio_up;
        case (ev.cmd)
            CMD_TICK:
            begin
                if (wired_mode)
                begin
                    if (limits.usb_idle_ms != '0 && timers.led_state &&
                        expired(ev.now_ms, timers.wired_mark, limits.usb_idle_ms))
                    begin
                        timers.led_state        = 1'b0;
                        timers.wired_sleep_mark = ev.now_ms;
                        timers.asleep           = 1'b0;
                        timers.idled            = 1'b1;
                    end
                    // The forced sleep measures from the LEDs-off time set just above.
                    if (!timers.asleep &&
                        expired(ev.now_ms, timers.wired_sleep_mark, limits.wired_sleep_ms))
                    begin
                        status.sleep_send       = SEND_WIRED;
                        timers.asleep           = 1'b1;
                        timers.wired_sleep_mark = ev.now_ms;
                    end
                end
                else
                begin
                    if (limits.radio_idle_ms != '0 && timers.led_state &&
                        expired(ev.now_ms, timers.radio_mark, limits.radio_idle_ms))
                    begin
                        timers.led_state        = 1'b0;
                        timers.idled            = 1'b1;
                        timers.asleep           = 1'b0;
                        timers.sides_sleep_mark = ev.now_ms;
                    end
                    if (limits.sides_sleep_enable && !timers.led_state && !timers.asleep &&
                        expired(ev.now_ms, timers.sides_sleep_mark, limits.sides_sleep_ms))
                    begin
                        status.sleep_send = SEND_BROADCAST;
                        timers.asleep     = 1'b1;
                    end
                end
            end
            CMD_KEY:
            begin
                if (timers.idled)
                begin
                    timers.led_state = 1'b1;
                    timers.idled     = 1'b0;
                end
                restart_marks(ev.now_ms);
            end
            CMD_LINK:
            begin
                if (timers.pending_connection)
                begin
                    timers.pending_connection = 1'b0;
                    restart_marks(ev.now_ms);
                end
                timers.led_state = 1'b1;
            end
            CMD_NEW_CONN:
                timers.pending_connection = 1'b1;
        endcase
        status.leds_on  = timers.led_state;
        status.idle_now = timers.idled;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t   ev;
        result_t due;
        result_t want;
        if (!rst_n)
        begin
            limits.usb_idle_ms        = USB_IDLE_RST;
            limits.radio_idle_ms      = RADIO_IDLE_RST;
            limits.sides_sleep_enable = 1'b0;
            limits.sides_sleep_ms     = SIDES_SLEEP_RST;
            limits.wired_sleep_ms     = WIRED_SLEEP_RST;
            timers                    = '0;
            timers.led_state          = 1'b1;
            status_due.delete();
            mismatches = 0;
            in_flight <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_USB_IDLE:    limits.usb_idle_ms        = cfg_data;
                    REG_RADIO_IDLE:  limits.radio_idle_ms      = cfg_data;
                    REG_SIDES_EN:    limits.sides_sleep_enable = cfg_data[0];
                    REG_SIDES_SLEEP: limits.sides_sleep_ms     = cfg_data;
                    REG_WIRED_SLEEP: limits.wired_sleep_ms     = cfg_data;
                    default:         ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (status_due.size() == 0)
                    report_mismatch("result word with no event outstanding",
                                    32'(m_tdata), '0);
                else
                begin
                    want = status_due.pop_front();
                    if (m_tdata[0] !== want.leds_on)
                        report_mismatch("leds_on", 32'(m_tdata[0]), 32'(want.leds_on));
                    if (m_tdata[2:1] !== want.sleep_send)
                        report_mismatch("sleep_send", 32'(m_tdata[2:1]),
                                        32'(want.sleep_send));
                    if (m_tdata[3] !== want.idle_now)
                        report_mismatch("idle_now", 32'(m_tdata[3]), 32'(want.idle_now));
                    if (m_tdata[OutDataW-1:4] !== '0)
                        report_mismatch("zero fill", 32'(m_tdata[OutDataW-1:4]), '0);
                end
            end

            if (s_tvalid && s_tready)
            begin
                ev.cmd         = s_tuser;
                ev.now_ms      = s_tdata[TimeW-1:0];
                ev.left_wired  = s_tdata[TimeW];
                ev.right_wired = s_tdata[TimeW+1];
                ev.radio_up    = s_tdata[TimeW+2];
                step_idle_timers(ev, due);
                status_due.push_back(due);
            end

            in_flight <= status_due.size();
        end
    end

endmodule

>>> tb/idle_led_and_sleep_timer_unit_test.sv
// ----------------------------------------------------------------------------
// idle_led_and_sleep_timer_unit_test
// Drives timed events and limit writes into the idle LED and sleep timer
// unit with random gaps and stalls on both streams; a checker module beside
// the unit predicts and compares every result word.
// ----------------------------------------------------------------------------
module idle_led_and_sleep_timer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ilst_pkg::*;

    localparam time         ClkPeriod  = 8ns;
    localparam int unsigned CycleLimit = 300000;
    localparam int unsigned PhaseCount = 10;
    localparam int unsigned PhaseItems = 88;
    localparam int unsigned LongHold   = 60;
    localparam logic [LimitW-1:0] LimitHigh = 26'd65535000;
    // Link bits as {radio_up, right_wired, left_wired} for wired mode.
    localparam logic [2:0]  WiredLinks = 3'b011;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata   = '0;
    logic [CmdW-1:0]     s_tuser   = CMD_TICK;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IdxW-1:0]     cfg_index = REG_USB_IDLE;
    logic [LimitW-1:0]   cfg_data  = '0;

    int unsigned mismatches;
    int unsigned in_flight;
    int unsigned cycle_count   = 0;
    int unsigned hold_requests = 0;
    bit          tx_steady     = 1'b0;
    bit          rx_steady     = 1'b0;
    logic [TimeW-1:0] stamp    = '0;

    idle_led_and_sleep_timer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    idle_timer_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result sink: random stalls per word, plus a long hold whenever asked.
    initial
    begin : result_sink
        int unsigned holds_served;
        int unsigned gap;
        holds_served = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_served != hold_requests)
            begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (LongHold) @(posedge clk);
            end
            gap = rx_steady ? 0 : $urandom_range(0, 11);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_event(input logic [CmdW-1:0] cmd, input logic [TimeW-1:0] now,
                              input logic lw, input logic rw, input logic radio);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(InDataW-TimeW-3){1'b0}}, radio, rw, lw, now};
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stops offering events and waits until every result word has been taken.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [LimitW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_limits(input logic [LimitW-1:0] usb, input logic [LimitW-1:0] radio,
                               input logic en, input logic [LimitW-1:0] sides,
                               input logic [LimitW-1:0] wired);
        logic [LimitW-1:0] en_word;
        // Only bit 0 of the enable register counts; the rest carries noise.
        en_word    = LimitW'($urandom());
        en_word[0] = en;
        write_reg(REG_USB_IDLE, usb);
        write_reg(REG_RADIO_IDLE, radio);
        write_reg(REG_SIDES_EN, en_word);
        write_reg(REG_SIDES_SLEEP, sides);
        write_reg(REG_WIRED_SLEEP, wired);
        write_reg(IdxW'(REG_WIRED_SLEEP + 1 + $urandom_range(0, 2)), LimitW'($urandom()));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [LimitW-1:0] pick_limit();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return LimitHigh;
            2:       return '1;
            default: return LimitW'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic run_phase(input logic wide_steps, input logic wired_pref);
        int unsigned count;
        int unsigned pick;
        logic [2:0]  links;
        count = 0;
        while (count < PhaseItems)
        begin
            if (wired_pref)
                links = WiredLinks;
            else
                do links = 3'($urandom_range(0, 7)); while (links == WiredLinks);
            if ($urandom_range(0, 99) < 15)
                links = 3'($urandom_range(0, 7));

            if (wide_steps && $urandom_range(0, 9) < 3)
                stamp += $urandom_range(0, 70000000);
            else if ($urandom_range(0, 49) == 0)
                stamp += $urandom();
            else
                stamp += $urandom_range(0, 24);

            pick = $urandom_range(0, 99);
            if (pick < 74)
                send_event(CMD_TICK, stamp, links[0], links[1], links[2]);
            else if (pick < 84)
                send_event(CMD_KEY, stamp, links[0], links[1], links[2]);
            else if (pick < 92)
            begin
                // A new connection followed by its link-up restarts the timers.
                send_event(CMD_NEW_CONN, stamp, links[0], links[1], links[2]);
                stamp += $urandom_range(0, 5);
                send_event(CMD_LINK, stamp, links[0], links[1], links[2]);
                count++;
            end
            else
                send_event(CmdW'($urandom_range(0, 3)), $urandom(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            count++;

            if ($urandom_range(0, 99) < 3)
                settle();
        end
    endtask

    initial
    begin : stimulus
        logic [LimitW-1:0] lim [4];
        logic              en;
        logic              wide;
        int unsigned       phase;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default limits: wired idle at the exact limit and one past it,
        // then the forced sleep of both sides.
        send_event(CMD_TICK, 32'd0, 1'b1, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd600000, 1'b1, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd600001, 1'b1, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd1800001, 1'b1, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd1800002, 1'b1, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd1800003, 1'b1, 1'b1, 1'b0);
        // Non-tick events ignore the link bits.
        send_event(CMD_KEY, 32'd2000000, 1'b0, 1'b0, 1'b1);
        send_event(CMD_NEW_CONN, 32'd2000100, 1'b1, 1'b0, 1'b1);
        send_event(CMD_LINK, 32'd2000200, 1'b0, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd2600201, 1'b0, 1'b0, 1'b1);
        // Link-up with no pending connection turns LEDs on but leaves idled set.
        send_event(CMD_LINK, 32'd2600300, 1'b1, 1'b1, 1'b1);
        send_event(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        settle();

        // Wired idle disabled, short limits, broadcast sleep enabled, time wrapping.
        load_limits('0, 26'd3, 1'b1, 26'd2, 26'd5);
        send_event(CMD_KEY, 32'hFFFF_FFFC, 1'b1, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd1, 1'b1, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd2, 1'b1, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd3, 1'b0, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd5, 1'b0, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd6, 1'b0, 1'b1, 1'b0);
        send_event(CMD_TICK, 32'd100, 1'b0, 1'b1, 1'b0);
        send_event(CMD_KEY, 32'd101, 1'b1, 1'b1, 1'b1);
        send_event(CMD_TICK, 32'd105, 1'b1, 1'b0, 1'b1);
        settle();

        for (phase = 0; phase < PhaseCount; phase++)
        begin
            en = ($urandom_range(0, 9) < 7);
            if (phase == 0)
            begin
                foreach (lim[k]) lim[k] = '0;
                en = 1'b1;
            end
            else if (phase == 1)
            begin
                foreach (lim[k]) lim[k] = LimitHigh;
                en = 1'b1;
            end
            else
                foreach (lim[k]) lim[k] = pick_limit();
            wide = 1'b0;
            foreach (lim[k])
                if (lim[k] > 1000) wide = 1'b1;

            load_limits(lim[0], lim[1], en, lim[2], lim[3]);

            tx_steady = (phase == 3 || phase == 6);
            rx_steady = (phase == 6);
            // Long receiver hold while events keep coming: the unit must back up.
            if (phase == 3)
                hold_requests++;

            if ($urandom_range(0, 3) == 0)
                stamp = 32'hFFFF_FF80 + $urandom_range(0, 63);
            else
                stamp = $urandom();
            if ($urandom_range(0, 4) != 0)
                send_event(CMD_KEY, stamp, 1'b1, 1'b1, 1'b0);

            run_phase(wide, 1'($urandom_range(0, 1)));
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            settle();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && in_flight == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
rtl/ilst_pkg.sv
rtl/ilst_core.sv
rtl/idle_led_and_sleep_timer_unit.sv
rtl/ilst_checker.sv
tb/idle_timer_checker.sv
tb/idle_led_and_sleep_timer_unit_test.sv
